FILE: hdl/sorted_multiset_table_top_assert.svh
// assertion macros used by the table rtl
`ifndef SORTED_MULTISET_TABLE_TOP_ASSERT_SVH
`define SORTED_MULTISET_TABLE_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define SMT_ASSERT_SAME(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("sorted multiset table: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define SMT_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("sorted multiset table: next-cycle check failed");

`endif

FILE: hdl/smt_pkg.sv
package smt_pkg;

    // number of cells in the chain
    localparam int CAPACITY = 64;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W = 7;

    // item action codes
    typedef enum logic [1:0] {
        ACT_SEARCH = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_ERASE  = 2'd2
    } t_action;

    // update command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

FILE: hdl/sorted_multiset_table_top.sv
// Ordered multiset of up to 64 signed 32-bit values held sorted in a chain of
// cells. An item carries an action in tuser (0 search, 1 add, 2 erase one
// copy, 3 no effect) and the value in tdata; each item yields one result with
// hit, add_refused and the count held afterwards. On acceptance all cells
// compare their value with the key at once; once the result register is
// free, the cells shift by one place to open or close a gap while the
// result is loaded into the output register. The next item is taken in the
// cycle after that, even while the previous result still waits. The
// store is empty after reset and needs no clearing pass.
`include "sorted_multiset_table_top_assert.svh"

module sorted_multiset_table_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] hit, [1] add_refused, [8:2] stored_count, rest zero
);

    localparam int CAP = smt_pkg::CAPACITY;

    logic                       r_busy;
    smt_pkg::t_action           r_act;
    logic [smt_pkg::VAL_W-1:0]  r_key;
    logic [smt_pkg::CNT_W-1:0]  r_count;
    logic [smt_pkg::CNT_W-1:0]  n_count;

    logic                       r_out_valid;
    logic                       r_hit;
    logic                       r_refused;
    logic [smt_pkg::OUT_CNT_W-1:0] r_out_cnt;

    logic                       cap;
    logic                       fire;
    logic                       present;
    logic                       full;
    logic                       n_hit;
    logic                       n_refused;
    smt_pkg::t_cell_cmd         cmd;

    logic [CAP-1:0]             live;
    logic [CAP-1:0]             lt;
    logic [CAP-1:0]             eq;
    logic [smt_pkg::VAL_W-1:0]  val [CAP];

    // handshake: one item in flight, result register decouples the output
    assign s_tready = !r_busy;
    assign cap      = s_tvalid && s_tready;
    assign fire     = r_busy && (!r_out_valid || m_tready);

    // capture the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (cap) begin
            r_busy <= 1'b1;
        end else if (fire) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cap) begin
            r_act <= smt_pkg::t_action'(s_tuser);
            r_key <= s_tdata;
        end
    end

    // occupancy of each cell from the count
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            live[i] = smt_pkg::CNT_W'(i) < r_count;
        end
    end

    // decide the action from the registered compares
    assign present = |eq;
    assign full    = (r_count == smt_pkg::CNT_W'(CAP));

    always_comb begin
        cmd       = '0;
        n_hit     = 1'b0;
        n_refused = 1'b0;
        n_count   = r_count;
        case (r_act)
            smt_pkg::ACT_SEARCH: begin
                n_hit = present;
            end
            smt_pkg::ACT_ADD: begin
                if (full) begin
                    n_refused = 1'b1;
                end else begin
                    n_hit   = 1'b1;
                    cmd.ins = fire;
                    n_count = r_count + 1'b1;
                end
            end
            smt_pkg::ACT_ERASE: begin
                if (present) begin
                    n_hit   = 1'b1;
                    cmd.del = fire;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // chain of cells
    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [smt_pkg::VAL_W-1:0] prev_val;
        logic                      prev_lt;
        logic [smt_pkg::VAL_W-1:0] next_val;

        if (g == 0) begin : g_first
            assign prev_val = r_key;
            assign prev_lt  = 1'b1;
        end else begin : g_mid
            assign prev_val = val[g-1];
            assign prev_lt  = lt[g-1];
        end

        if (g == CAP - 1) begin : g_last
            assign next_val = val[g];
        end else begin : g_inner
            assign next_val = val[g+1];
        end

        smt_cell u_cell (
            .i_clk      (i_clk),
            .i_cap      (cap),
            .i_key      (s_tdata),
            .i_live     (live[g]),
            .i_cmd      (cmd),
            .i_ins_val  (r_key),
            .i_prev_val (prev_val),
            .i_prev_lt  (prev_lt),
            .i_next_val (next_val),
            .o_val      (val[g]),
            .o_lt       (lt[g]),
            .o_eq       (eq[g])
        );
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (fire) begin
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_hit     <= n_hit;
            r_refused <= n_refused;
            r_out_cnt <= smt_pkg::OUT_CNT_W'(n_count);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {7'd0, r_out_cnt, r_refused, r_hit};

    // checks
    `SMT_ASSERT_SAME(a_count_bound, 1'b1, r_count <= smt_pkg::CNT_W'(CAP))
    `SMT_ASSERT_NEXT(a_busy_after_take, cap, r_busy)
    `SMT_ASSERT_SAME(a_hit_excl_refused, r_out_valid, !(r_hit && r_refused))
    `SMT_ASSERT_NEXT(a_add_grows, fire && r_act == smt_pkg::ACT_ADD && !full, r_count == $past(r_count) + 1'b1)

endmodule

FILE: hdl/smt_cell.sv
module smt_cell (
    input  logic                        i_clk,
    input  logic                        i_cap,
    input  logic [smt_pkg::VAL_W-1:0]   i_key,
    input  logic                        i_live,
    input  smt_pkg::t_cell_cmd          i_cmd,
    input  logic [smt_pkg::VAL_W-1:0]   i_ins_val,
    input  logic [smt_pkg::VAL_W-1:0]   i_prev_val,
    input  logic                        i_prev_lt,
    input  logic [smt_pkg::VAL_W-1:0]   i_next_val,
    output logic [smt_pkg::VAL_W-1:0]   o_val,
    output logic                        o_lt,
    output logic                        o_eq
);

    logic [smt_pkg::VAL_W-1:0] r_val;
    logic [smt_pkg::VAL_W-1:0] n_val;
    logic                      r_lt;
    logic                      r_eq;

    // compare held value against the incoming key when an item is taken
    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_lt <= i_live && ($signed(r_val) < $signed(i_key));
            r_eq <= i_live && (r_val == i_key);
        end
    end

    // cells at or above the sorted position shift up on insert, down on erase
    always_comb begin
        n_val = r_val;
        if (i_cmd.ins && !r_lt) begin
            n_val = i_prev_lt ? i_ins_val : i_prev_val;
        end else if (i_cmd.del && !r_lt) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule
